[design/adaptive_voice_threshold_detector_assert.svh]
// Assertion macros shared by the checker files of the voice threshold detector.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ADAPTIVE_VOICE_THRESHOLD_DETECTOR_ASSERT_SVH
`define ADAPTIVE_VOICE_THRESHOLD_DETECTOR_ASSERT_SVH

// Next-cycle implication, disabled while reset is high.
`define AVTD_ASSERT_NEXT(label, clock, reset, cond, conseq) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
    else $error("assertion failed");

// Same-cycle implication, disabled while reset is high.
`define AVTD_ASSERT_SAME(label, clock, reset, cond, conseq) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
    else $error("assertion failed");

`endif

[design/avtd_pkg.sv]
// Shared constants and types of the adaptive voice threshold detector.
// Used by the top level and the history scan unit; depends on nothing.
package avtd_pkg;

  localparam int HistoryDepthDefault = 64;
  localparam int PeakWidth           = 16;
  localparam int ThrWidth            = 15;
  localparam int TickWidth           = 3;
  localparam int ProdWidth           = 18;

  localparam logic [ThrWidth-1:0]  FloorReset   = 15'd300;
  localparam logic [ThrWidth-1:0]  CeilingReset = 15'd3000;
  localparam logic [ThrWidth-1:0]  InitReset    = 15'd1000;
  localparam logic [TickWidth-1:0] TickLast     = 3'd7;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegFloor   = 2'd0;
  localparam logic [1:0] RegCeiling = 2'd1;
  localparam logic [1:0] RegInit    = 2'd2;

  typedef struct packed {
    logic                        done;
    logic signed [PeakWidth-1:0] low;
  } scan_result_t;

endpackage

[design/avtd_history.sv]
// Peak history memory with a sequential minimum scan over all entries.
// Depends on avtd_pkg for widths and the scan result type.
module avtd_history #(
  parameter int DEPTH = avtd_pkg::HistoryDepthDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [$clog2(DEPTH)-1:0]              wr_addr,
  input  logic signed [avtd_pkg::PeakWidth-1:0] wr_data,
  input  logic                                  start,
  output avtd_pkg::scan_result_t                result
);

  localparam int AW = $clog2(DEPTH);

  logic signed [avtd_pkg::PeakWidth-1:0] mem [DEPTH];
  logic signed [avtd_pkg::PeakWidth-1:0] rd_data;
  logic signed [avtd_pkg::PeakWidth-1:0] low;
  logic [AW-1:0]                         cnt;
  logic                                  busy;
  logic                                  pend;
  logic                                  first;
  logic                                  done;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[cnt];
  end

  // Read data is registered, so it lags the address; pend marks it valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= 1'b0;
      first <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      pend <= busy;
      done <= pend && !busy;
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        cnt   <= '0;
      end else if (busy) begin
        if (cnt == AW'(DEPTH - 1)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (pend) begin
        first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && (first || rd_data < low)) begin
      low <= rd_data;
    end
  end

  assign result.done = done;
  assign result.low  = low;

endmodule

[design/adaptive_voice_threshold_detector.sv]
// Channel   | Direction | Payload
// s_axis    | in        | frame_peak, operation
// m_axis    | out       | is_voice, threshold_now, estimate_ready
// APB       | in/out    | threshold_floor, threshold_ceiling, initial_threshold
//
// An item that does not trigger a recomputation closes the input until its result leaves the holding stage.
// A recomputation reads every history entry once through the single read port;
// the input takes no new item until the scan, multiply and clamp are done.
// A finished result waits in a holding stage while the output register is stalled.
// Reset is synchronous; the history memory is not cleared as it is only scanned when full.
module adaptive_voice_threshold_detector #(
  parameter int HISTORY_DEPTH = avtd_pkg::HistoryDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] frame_peak, [16] operation, [23:17] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] is_voice, [15:1] threshold_now, [16] estimate_ready
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int TW = avtd_pkg::ThrWidth;
  localparam int PW = avtd_pkg::ProdWidth;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_MUL, ST_CLAMP} state_t;

  state_t                                state;
  logic [TW-1:0]                         thr_floor;
  logic [TW-1:0]                         thr_ceiling;
  logic [TW-1:0]                         thr_init;
  logic [TW-1:0]                         threshold;
  logic                                  ready_flag;
  logic [AW-1:0]                         write_pointer;
  logic [FW-1:0]                         fill_count;
  logic [FW-1:0]                         fill_next;
  logic [avtd_pkg::TickWidth-1:0]        update_tick;
  logic signed [PW-1:0]                  prod;
  logic signed [PW-1:0]                  clamp_lo;
  logic signed [PW-1:0]                  clamp_hi;
  logic                                  res_valid;
  logic                                  res_voice;
  logic                                  out_valid;
  logic [23:0]                           out_data;
  logic                                  accept;
  logic                                  observe;
  logic                                  cfg_wr;
  logic signed [avtd_pkg::PeakWidth-1:0] peak;
  logic                                  voice;
  logic                                  scan_start;
  avtd_pkg::scan_result_t                scan;

  assign peak     = s_tdata[15:0];
  assign voice    = peak > $signed({1'b0, threshold});
  assign s_tready = (state == ST_IDLE) && !res_valid;
  assign accept   = s_tvalid && s_tready;
  assign observe  = accept && s_tdata[16];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign fill_next  = (fill_count < FW'(HISTORY_DEPTH)) ? fill_count + 1'b1 : fill_count;
  assign scan_start = observe && (fill_next == FW'(HISTORY_DEPTH)) &&
                      (update_tick == avtd_pkg::TickLast);

  // Floor first, then ceiling, so the ceiling wins when the two cross.
  always_comb begin
    clamp_lo = (prod < $signed(PW'(thr_floor))) ? $signed(PW'(thr_floor)) : prod;
    clamp_hi = (clamp_lo > $signed(PW'(thr_ceiling))) ? $signed(PW'(thr_ceiling)) : clamp_lo;
  end

  always_comb begin
    case (paddr[3:2])
      avtd_pkg::RegFloor:   prdata = {17'd0, thr_floor};
      avtd_pkg::RegCeiling: prdata = {17'd0, thr_ceiling};
      avtd_pkg::RegInit:    prdata = {17'd0, thr_init};
      default:              prdata = '0;
    endcase
  end

  avtd_history #(
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (observe),
    .wr_addr (write_pointer),
    .wr_data (peak),
    .start   (scan_start),
    .result  (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      thr_floor     <= avtd_pkg::FloorReset;
      thr_ceiling   <= avtd_pkg::CeilingReset;
      thr_init      <= avtd_pkg::InitReset;
      threshold     <= avtd_pkg::InitReset;
      ready_flag    <= 1'b0;
      write_pointer <= '0;
      fill_count    <= '0;
      update_tick   <= '0;
      res_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          avtd_pkg::RegFloor:   thr_floor   <= pwdata[TW-1:0];
          avtd_pkg::RegCeiling: thr_ceiling <= pwdata[TW-1:0];
          avtd_pkg::RegInit: begin
            thr_init <= pwdata[TW-1:0];
            if (!ready_flag) begin
              threshold <= pwdata[TW-1:0];
            end
          end
          default: ;
        endcase
      end

      if (res_valid && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
        out_data  <= {7'd0, ready_flag, threshold, res_voice};
        res_valid <= 1'b0;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_voice <= voice;
            if (observe) begin
              write_pointer <= (write_pointer == AW'(HISTORY_DEPTH - 1)) ?
                               '0 : write_pointer + 1'b1;
              fill_count    <= fill_next;
              if (fill_next == FW'(HISTORY_DEPTH)) begin
                update_tick <= update_tick + 1'b1;
              end
            end
            if (scan_start) begin
              state <= ST_SCAN;
            end else begin
              res_valid <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (scan.done) begin
            prod  <= (PW'($signed(scan.low)) <<< 1) + PW'($signed(scan.low));
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          threshold  <= clamp_hi[TW-1:0];
          ready_flag <= 1'b1;
          res_valid  <= 1'b1;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

[design/avtd_checker.sv]
// Port-level checks of the adaptive voice threshold detector and their bind.
// Depends on the assertion macro header and the top level's port list.
`include "adaptive_voice_threshold_detector_assert.svh"

module avtd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        pready
);

  // A stalled result transaction keeps its payload.
  `AVTD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // One item at a time: the input closes right after a transaction.
  `AVTD_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)

  // Padding bits of a result stay zero.
  `AVTD_ASSERT_SAME(a_out_pad, clk, rst, m_tvalid, m_tdata[23:17] == 7'd0)

  // The estimate flag, once shown, is never withdrawn outside reset.
  `AVTD_ASSERT_NEXT(a_ready_sticky, clk, rst, m_tvalid && m_tdata[16],
                    !m_tvalid || m_tdata[16])

  `AVTD_ASSERT_SAME(a_pready, clk, rst, 1'b1, pready)

endmodule

bind adaptive_voice_threshold_detector avtd_checker u_avtd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

[dv/adaptive_voice_threshold_detector_test.sv]
// Self-checking testbench for the adaptive voice threshold detector.
// Depends on avtd_pkg and the detector RTL; it needs no other file.
module adaptive_voice_threshold_detector_test;
  import avtd_pkg::*;

  localparam int CycleLimit   = 1000000;
  localparam int PhaseItems   = 200;
  localparam int PhaseCount   = 8;
  localparam int HoldOffLen   = 600;
  localparam int ObservePct   = 85;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic                voice;
    logic [ThrWidth-1:0] thr;
    logic                ready;
  } verdict_t;

  typedef struct {
    logic signed [PeakWidth-1:0] peak;
    logic                        observe;
    bit                          typed;
    verdict_t                    want;
  } stim_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [15:0] frame_peak, [16] operation, [23:17] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [0] is_voice, [15:1] threshold_now, [16] estimate_ready
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  adaptive_voice_threshold_detector uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the detector: registers and noise history.
  logic [ThrWidth-1:0]         floor_reg   = FloorReset;
  logic [ThrWidth-1:0]         ceiling_reg = CeilingReset;
  logic [ThrWidth-1:0]         init_reg    = InitReset;
  logic signed [PeakWidth-1:0] peak_ring [HistoryDepthDefault];
  int                          ring_ptr    = 0;
  int                          ring_fill   = 0;
  logic [TickWidth-1:0]        tick        = '0;
  logic [ThrWidth-1:0]         voice_thr   = InitReset;
  logic                        est_ready   = 1'b0;

  verdict_t verdict_q[$];
  int       mismatches  = 0;
  int       cycle_count = 0;

  // Stimulus shaping, set per phase by the main sequence.
  int gap_pct    = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int noise_base = 0;
  int noise_span = 500;

  // A directed row carries its own expectation alongside the data.
  bit       typed_on  = 1'b0;
  verdict_t typed_val = '0;

  function automatic verdict_t classify_and_observe(logic signed [PeakWidth-1:0] peak,
                                                    logic observe);
    verdict_t v;
    int low;
    int thr_calc;
    v.voice = int'(peak) > int'(voice_thr);
    if (observe) begin
      peak_ring[ring_ptr] = peak;
      ring_ptr = (ring_ptr + 1) % HistoryDepthDefault;
      if (ring_fill < HistoryDepthDefault) ring_fill++;
      if (ring_fill == HistoryDepthDefault) begin
        if (tick != TickLast) begin
          tick = tick + 1'b1;
        end else begin
          tick = '0;
          low = int'(peak_ring[0]);
          for (int i = 1; i < HistoryDepthDefault; i++) begin
            if (int'(peak_ring[i]) < low) low = int'(peak_ring[i]);
          end
          thr_calc = low * 3;
          if (thr_calc < int'(floor_reg)) thr_calc = int'(floor_reg);
          if (thr_calc > int'(ceiling_reg)) thr_calc = int'(ceiling_reg);
          voice_thr = thr_calc[ThrWidth-1:0];
          est_ready = 1'b1;
        end
      end
    end
    v.thr   = voice_thr;
    v.ready = est_ready;
    return v;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Results are checked before new items are predicted, so a result can
  // never be matched against the transaction accepted at the same edge.
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[0], m_tdata[15:1], m_tdata[16]};
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result, threshold", -1, int'(got.thr));
        end else begin
          want = verdict_q.pop_front();
          if (got.voice !== want.voice)
            report_mismatch("is_voice", int'(want.voice), int'(got.voice));
          if (got.thr !== want.thr)
            report_mismatch("threshold_now", int'(want.thr), int'(got.thr));
          if (got.ready !== want.ready)
            report_mismatch("estimate_ready", int'(want.ready), int'(got.ready));
        end
      end
      if (s_tvalid && s_tready) begin
        want = classify_and_observe(s_tdata[15:0], s_tdata[16]);
        if (typed_on) want = typed_val;
        verdict_q.push_back(want);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldOffLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** adaptive_voice_threshold_detector: FAILED **");
      $finish;
    end
  end

  // Called just after a falling edge; returns just after one.
  task automatic send_item(logic signed [PeakWidth-1:0] peak, logic observe,
                           bit typed, verdict_t want);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= {7'b0, observe, peak};
    typed_on  = typed;
    typed_val = want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ThrWidth-1:0] value);
    logic [31:0] word;
    word = {17'($urandom_range(0, 131071)), value};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegFloor:   floor_reg   = word[ThrWidth-1:0];
      RegCeiling: ceiling_reg = word[ThrWidth-1:0];
      RegInit: begin
        init_reg = word[ThrWidth-1:0];
        if (!est_ready) voice_thr = init_reg;
      end
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx != RegUnused) begin
      @(negedge clk);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata[ThrWidth-1:0] !== value)
        report_mismatch("register read", int'(value), int'(prdata));
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [PeakWidth-1:0] random_peak();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) return 16'(noise_base + $urandom_range(0, noise_span));
    case (pick)
      13:      return 16'sh8000;
      14:      return 16'sh7fff;
      15:      return 16'($urandom_range(0, 65535));
      16:      return 16'(-int'($urandom_range(1, 32768)));
      default: return 16'($urandom_range(noise_base, 32767));
    endcase
  endfunction

  // Directed rows at reset settings: threshold 1000, no estimate yet.
  stim_row_t directed [16] = '{
    '{16'sd1000,   1'b0, 1'b1, '{1'b0, 15'd1000, 1'b0}},
    '{16'sd1001,   1'b0, 1'b1, '{1'b1, 15'd1000, 1'b0}},
    '{16'sd999,    1'b1, 1'b1, '{1'b0, 15'd1000, 1'b0}},
    '{16'sd32767,  1'b1, 1'b1, '{1'b1, 15'd1000, 1'b0}},
    '{-16'sd32768, 1'b1, 1'b1, '{1'b0, 15'd1000, 1'b0}},
    '{-16'sd1,     1'b0, 1'b1, '{1'b0, 15'd1000, 1'b0}},
    '{16'sd0,      1'b1, 1'b1, '{1'b0, 15'd1000, 1'b0}},
    '{16'sh5555,   1'b1, 1'b1, '{1'b1, 15'd1000, 1'b0}},
    '{16'shaaaa,   1'b0, 1'b1, '{1'b0, 15'd1000, 1'b0}},
    '{16'sd1000,   1'b1, 1'b1, '{1'b0, 15'd1000, 1'b0}},
    '{16'sd1001,   1'b1, 1'b1, '{1'b1, 15'd1000, 1'b0}},
    '{16'sd32767,  1'b0, 1'b1, '{1'b1, 15'd1000, 1'b0}},
    '{-16'sd32768, 1'b0, 1'b1, '{1'b0, 15'd1000, 1'b0}},
    '{16'sd300,    1'b1, 1'b0, '{1'b0, 15'd0,    1'b0}},
    '{16'sd3000,   1'b1, 1'b0, '{1'b0, 15'd0,    1'b0}},
    '{16'sd1,      1'b0, 1'b0, '{1'b0, 15'd0,    1'b0}}
  };

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i])
      send_item(directed[i].peak, directed[i].observe, directed[i].typed, directed[i].want);
    s_tvalid <= 1'b0;
    typed_on = 1'b0;
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      // No estimate exists before the first phase, so the initial threshold
      // write still reaches the live threshold there; later it must not.
      case (p)
        0: begin
          write_reg(RegInit, 15'h7fff);
          write_reg(RegInit, 15'd0);
        end
        1: begin
          write_reg(RegFloor, 15'd0);
          write_reg(RegCeiling, 15'h7fff);
        end
        2: begin
          write_reg(RegFloor, 15'h7fff);
          write_reg(RegCeiling, 15'd0);
        end
        3: begin
          write_reg(RegFloor, 15'($urandom_range(0, 4000)));
          write_reg(RegCeiling, 15'($urandom_range(0, 32767)));
          write_reg(RegInit, 15'($urandom_range(0, 32767)));
        end
        4: begin
          write_reg(RegUnused, 15'($urandom_range(0, 32767)));
          write_reg(RegFloor, FloorReset);
          write_reg(RegCeiling, CeilingReset);
        end
        5: begin
          write_reg(RegFloor, 15'h7fff);
          write_reg(RegCeiling, 15'h7fff);
        end
        6: begin
          write_reg(RegFloor, 15'd0);
          write_reg(RegCeiling, 15'd0);
        end
        default: begin
          write_reg(RegFloor, 15'($urandom_range(0, 32767)));
          write_reg(RegCeiling, 15'($urandom_range(0, 32767)));
        end
      endcase
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 75; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 75; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      noise_base = $urandom_range(0, 3000);
      noise_span = $urandom_range(20, 2000);
      @(negedge clk);
      if (p == 2) hold_req++;
      repeat (PhaseItems)
        send_item(random_peak(), $urandom_range(0, 99) < ObservePct, 1'b0, '0);
      s_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (HistoryDepthDefault + 8) @(posedge clk);
    if (mismatches == 0)
      $display("** adaptive_voice_threshold_detector: PASSED **");
    else
      $display("** adaptive_voice_threshold_detector: FAILED **");
    $finish;
  end

endmodule
